[rtl/rsct_pkg.sv]
// ----------------------------------------------------------------------------
// rsct_pkg: shared types and constants of the read substitution table
// Request codes, table size and the request record that walks the cell chain.
// ----------------------------------------------------------------------------
package rsct_pkg;

    localparam int TABLE_ENTRIES = 16;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_READ  = 2'd2
    } req_code_t;

    // Request record carried from cell to cell, one stage per cell
    typedef struct packed {
        logic       valid;
        req_code_t  req_type;
        logic [15:0] address;
        logic [7:0] bus_data;
        logic [7:0] replace_value;
        logic [7:0] compare_value;
        logic       compare_on;
        logic       enable;      // global enable sampled at entry
        logic       found;       // load: address already held
        logic       placed;      // load: entry written
        logic       subst;       // read: replacement selected
        logic [7:0] subst_data;  // read: replacement byte
    } req_t;

endpackage

[rtl/rsct_cell.sv]
// ----------------------------------------------------------------------------
// rsct_cell: one table slot of the substitution chain
// Holds one entry, acts on the passing request and registers it onward.
// ----------------------------------------------------------------------------
module rsct_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  rsct_pkg::req_t req_in,
    output rsct_pkg::req_t req_out,
    output logic           occupied
);

    logic           occupied_reg;
    logic           occupied_next;
    logic [15:0]    addr_reg;
    logic [7:0]     value_reg;
    logic [7:0]     compare_reg;
    logic           has_compare_reg;
    logic           write_entry;
    logic           match;
    rsct_pkg::req_t req_next;
    rsct_pkg::req_t req_reg;

    assign match = occupied_reg && (addr_reg == req_in.address);

    always_comb begin
        req_next      = req_in;
        occupied_next = occupied_reg;
        write_entry   = 1'b0;
        if (req_in.valid) begin
            case (req_in.req_type)
                rsct_pkg::REQ_CLEAR: begin
                    occupied_next = 1'b0;
                end
                rsct_pkg::REQ_LOAD: begin
                    if (match) begin
                        req_next.found = 1'b1;
                    end else if (!occupied_reg && !req_in.found && !req_in.placed) begin
                        // first free slot: every held entry has been checked
                        write_entry     = 1'b1;
                        occupied_next   = 1'b1;
                        req_next.placed = 1'b1;
                    end
                end
                rsct_pkg::REQ_READ: begin
                    if (match && req_in.enable &&
                        (!has_compare_reg || compare_reg == req_in.bus_data)) begin
                        req_next.subst      = 1'b1;
                        req_next.subst_data = value_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupied_reg <= 1'b0;
            req_reg      <= '0;
        end else if (advance) begin
            occupied_reg <= occupied_next;
            req_reg      <= req_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && write_entry) begin
            addr_reg        <= req_in.address;
            value_reg       <= req_in.replace_value;
            compare_reg     <= req_in.compare_value;
            has_compare_reg <= req_in.compare_on;
        end
    end

    assign req_out  = req_reg;
    assign occupied = occupied_reg;

endmodule

[rtl/read_substitution_cheat_table.sv]
// ----------------------------------------------------------------------------
// read_substitution_cheat_table: bus read patcher with a substitute table
// Requests clear the table, load an entry or patch one bus read byte.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  req_type, address, bus_data,
//                                         replace_value, compare_value,
//                                         compare_on
//  m_       out        m_valid / m_ready  read_data, substituted, accepted
//  cfg_     in         cfg_we             cfg_wdata (global enable)
//
// A request walks the row of TABLE_ENTRIES cells and is registered in each
// cell in turn; a new request may enter every cycle while the row is not
// held for a waiting result.
// Reset empties the table and sets the global enable; no clearing pass.
// When a result waits and m_ready is low, the whole row holds and s_ready
// drops until the result is taken.
// ----------------------------------------------------------------------------
module read_substitution_cheat_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_bus_data,
    input  logic [7:0]  s_replace_value,
    input  logic [7:0]  s_compare_value,
    input  logic        s_compare_on,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_substituted,
    output logic        m_accepted
);

    logic                                  cheats_enabled_reg;
    logic                                  advance;
    rsct_pkg::req_t                        chain [0:rsct_pkg::TABLE_ENTRIES];
    logic [rsct_pkg::TABLE_ENTRIES-1:0]    occupied;
    rsct_pkg::req_t                        last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cheats_enabled_reg <= 1'b1;
        end else if (cfg_we) begin
            cheats_enabled_reg <= cfg_wdata;
        end
    end

    // hold the whole row while a result waits
    assign advance = m_ready || !last.valid;
    assign s_ready = advance;

    always_comb begin
        chain[0]               = '0;
        chain[0].valid         = s_valid;
        chain[0].req_type      = rsct_pkg::req_code_t'(s_req_type);
        chain[0].address       = s_address;
        chain[0].bus_data      = s_bus_data;
        chain[0].replace_value = s_replace_value;
        chain[0].compare_value = s_compare_value;
        chain[0].compare_on    = s_compare_on;
        chain[0].enable        = cheats_enabled_reg;
    end

    for (genvar i = 0; i < rsct_pkg::TABLE_ENTRIES; i++) begin : g_cell
        rsct_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .req_in   (chain[i]),
            .req_out  (chain[i+1]),
            .occupied (occupied[i])
        );
    end

    assign last    = chain[rsct_pkg::TABLE_ENTRIES];
    assign m_valid = last.valid;

    always_comb begin
        m_read_data   = 8'd0;
        m_substituted = 1'b0;
        m_accepted    = 1'b0;
        case (last.req_type)
            rsct_pkg::REQ_CLEAR: begin
                m_accepted = 1'b1;
            end
            rsct_pkg::REQ_LOAD: begin
                m_accepted = last.placed;
            end
            rsct_pkg::REQ_READ: begin
                m_accepted    = 1'b1;
                m_substituted = last.subst;
                m_read_data   = last.subst ? last.subst_data : last.bus_data;
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a waiting result stays put until taken
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable({m_read_data, m_substituted, m_accepted})))
        else $error("result changed while waiting");

    a_clear_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && s_valid && s_req_type == rsct_pkg::REQ_CLEAR) |=> !occupied[0])
        else $error("clear did not empty the first slot");

    a_load_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (last.valid && last.placed) |-> !last.found)
        else $error("load both placed and found as duplicate");

    a_subst_read_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (last.valid && last.subst) |-> (last.req_type == rsct_pkg::REQ_READ && last.enable))
        else $error("substitution outside an enabled read");
`endif

endmodule
